// ===== hdl/vmps_pkg.sv =====
package vmps_pkg;

   // request commands
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_MOVE = 2'd1;
   localparam logic [1:0] CMD_INIT = 2'd2;

   // step actions
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_OPEN  = 2'd1;
   localparam logic [1:0] ACT_CLOSE = 2'd2;

   // register indexes
   localparam int unsigned CsrIndexBits = 3;
   localparam logic [CsrIndexBits-1:0] CSR_STEP_INTERVAL     = 3'd0;
   localparam logic [CsrIndexBits-1:0] CSR_OVERRUN_LIMIT     = 3'd1;
   localparam logic [CsrIndexBits-1:0] CSR_ZERO_EXTRA_PULSES = 3'd2;
   localparam logic [CsrIndexBits-1:0] CSR_POWER_ON_POSITION = 3'd3;
   localparam logic [CsrIndexBits-1:0] CSR_MOTOR_ENABLE      = 3'd4;

   localparam int unsigned CsrDataBits = 16;

   // register reset values
   localparam logic [7:0]  RST_STEP_INTERVAL     = 8'd15;
   localparam logic [9:0]  RST_OVERRUN_LIMIT     = 10'd300;
   localparam logic [7:0]  RST_ZERO_EXTRA_PULSES = 8'd30;
   localparam logic [15:0] RST_POWER_ON_POSITION = 16'd205;
   localparam logic        RST_MOTOR_ENABLE      = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] target_pos;
      logic [7:0]  open_overshoot;
      logic        origin_sensed;
   } req_type;

   typedef struct packed {
      logic [1:0]  step_action;
      logic        running;
      logic [15:0] position;
      logic        stopped;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  step_interval;
      logic [9:0]  overrun_limit;
      logic [7:0]  zero_extra_pulses;
      logic [15:0] power_on_position;
      logic        motor_enable;
   } cfg_type;

endpackage

// ===== hdl/vmps_csr.sv =====
module vmps_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [vmps_pkg::CsrIndexBits-1:0]      csr_index,
   input  logic [vmps_pkg::CsrDataBits-1:0]       csr_wdata,
   output vmps_pkg::cfg_type                      cfg
);

   vmps_pkg::cfg_type cfg_ff;
   vmps_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            vmps_pkg::CSR_STEP_INTERVAL:     cfg_in.step_interval     = csr_wdata[7:0];
            vmps_pkg::CSR_OVERRUN_LIMIT:     cfg_in.overrun_limit     = csr_wdata[9:0];
            vmps_pkg::CSR_ZERO_EXTRA_PULSES: cfg_in.zero_extra_pulses = csr_wdata[7:0];
            vmps_pkg::CSR_POWER_ON_POSITION: cfg_in.power_on_position = csr_wdata[15:0];
            vmps_pkg::CSR_MOTOR_ENABLE:      cfg_in.motor_enable      = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_interval     <= vmps_pkg::RST_STEP_INTERVAL;
         cfg_ff.overrun_limit     <= vmps_pkg::RST_OVERRUN_LIMIT;
         cfg_ff.zero_extra_pulses <= vmps_pkg::RST_ZERO_EXTRA_PULSES;
         cfg_ff.power_on_position <= vmps_pkg::RST_POWER_ON_POSITION;
         cfg_ff.motor_enable      <= vmps_pkg::RST_MOTOR_ENABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/vmps_step_logic.sv =====
module vmps_step_logic #(
   parameter int POSITION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  vmps_pkg::req_type req,
   input  vmps_pkg::cfg_type cfg,
   output vmps_pkg::rsp_type rsp
);

   localparam int Pw1 = POSITION_BITS + 1;
   localparam logic [32:0] PosMaxWide = (33'd1 << POSITION_BITS) - 33'd1;
   localparam logic [POSITION_BITS-1:0] PosTop = PosMaxWide[POSITION_BITS-1:0];

   logic [POSITION_BITS-1:0] cur_ff, cur_in;
   logic [POSITION_BITS-1:0] goal_ff, goal_in;
   logic                     run_ff, run_in;
   logic [7:0]               tick_ff, tick_in;
   logic [9:0]               overrun_ff, overrun_in;
   logic [7:0]               pend_ff, pend_in;

   logic [POSITION_BITS-1:0] target_sat;
   logic [POSITION_BITS-1:0] power_on_sat;
   logic [POSITION_BITS-1:0] cur_inc;
   logic [POSITION_BITS-1:0] pend_wide;
   logic [POSITION_BITS-1:0] goal_trim;
   logic [POSITION_BITS:0]   extra_sum;
   logic [POSITION_BITS-1:0] cur_extra;
   logic [7:0]               move_pend;
   logic [POSITION_BITS:0]   goal_sum;
   logic [POSITION_BITS-1:0] move_goal;
   logic [31:0]              pos_wide;
   logic [1:0]               action;
   logic                     stopped;

   function automatic logic [POSITION_BITS-1:0] sat_field(input logic [15:0] v);
      logic [32:0] wide;
      begin
         wide = 33'(v);
         if (wide > PosMaxWide) begin
            return PosTop;
         end
         return wide[POSITION_BITS-1:0];
      end
   endfunction

   always_comb begin
      target_sat   = sat_field(req.target_pos);
      power_on_sat = sat_field(cfg.power_on_position);
      cur_inc      = (cur_ff == PosTop) ? cur_ff : cur_ff + POSITION_BITS'(1);
      pend_wide    = POSITION_BITS'(pend_ff);
      goal_trim    = (pend_wide > goal_ff) ? '0 : goal_ff - pend_wide;
      extra_sum    = Pw1'(cur_ff) + Pw1'(cfg.zero_extra_pulses);
      cur_extra    = extra_sum[POSITION_BITS] ? PosTop : extra_sum[POSITION_BITS-1:0];
      move_pend    = (target_sat != '0 && cur_ff < target_sat) ? req.open_overshoot : 8'd0;
      goal_sum     = Pw1'(target_sat) + Pw1'(move_pend);
      move_goal    = goal_sum[POSITION_BITS] ? PosTop : goal_sum[POSITION_BITS-1:0];
   end

   always_comb begin
      cur_in     = cur_ff;
      goal_in    = goal_ff;
      run_in     = run_ff;
      tick_in    = tick_ff;
      overrun_in = overrun_ff;
      pend_in    = pend_ff;
      action     = vmps_pkg::ACT_NONE;
      stopped    = 1'b0;
      unique case (req.cmd)
         vmps_pkg::CMD_TICK: begin
            if (tick_ff != 8'd0) begin
               tick_in = tick_ff - 8'd1;
            end else begin
               tick_in = cfg.step_interval;
               if (cfg.motor_enable && run_ff) begin
                  if (goal_ff == cur_ff) begin
                     // take the open overshoot back off before stopping
                     if (pend_ff != 8'd0) begin
                        goal_in = goal_trim;
                        pend_in = 8'd0;
                     end else begin
                        run_in  = 1'b0;
                        stopped = 1'b1;
                     end
                  end else if (goal_ff > cur_ff) begin
                     cur_in = cur_inc;
                     action = vmps_pkg::ACT_OPEN;
                  end else if (req.origin_sensed && overrun_ff >= cfg.overrun_limit) begin
                     // home at the overrun limit
                     cur_in  = '0;
                     goal_in = '0;
                     run_in  = 1'b0;
                     stopped = 1'b1;
                  end else begin
                     if (req.origin_sensed) begin
                        overrun_in = overrun_ff + 10'd1;
                     end
                     cur_in = cur_ff - POSITION_BITS'(1);
                     action = vmps_pkg::ACT_CLOSE;
                  end
               end
            end
         end
         vmps_pkg::CMD_MOVE: begin
            if (!run_ff && cur_ff != target_sat) begin
               run_in     = 1'b1;
               tick_in    = cfg.step_interval;
               overrun_in = 10'd0;
               pend_in    = move_pend;
               goal_in    = move_goal;
               if (target_sat == '0) begin
                  cur_in = cur_extra;
               end
            end
         end
         vmps_pkg::CMD_INIT: begin
            cur_in = req.origin_sensed ? '0 : power_on_sat;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff     <= '0;
         goal_ff    <= '0;
         run_ff     <= 1'b0;
         tick_ff    <= 8'd0;
         overrun_ff <= 10'd0;
         pend_ff    <= 8'd0;
      end else if (advance) begin
         cur_ff     <= cur_in;
         goal_ff    <= goal_in;
         run_ff     <= run_in;
         tick_ff    <= tick_in;
         overrun_ff <= overrun_in;
         pend_ff    <= pend_in;
      end
   end

   assign pos_wide = 32'(cur_in);

   always_comb begin
      rsp.step_action = action;
      rsp.running     = run_in;
      rsp.position    = pos_wide[15:0];
      rsp.stopped     = stopped;
   end

endmodule

// ===== hdl/valve_motor_position_sequencer_core.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_data  (vmps_pkg::req_type)
// rsp       out        rsp_valid / rsp_ready  rsp_data  (vmps_pkg::rsp_type)
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One request per cycle sustained while results are taken; a result passes from the input
// register through the step logic into the result register before it is presented.
// Synchronous reset clears valids, motion state and restores register defaults.
// A stalled result holds the result register; a full input register then holds and
// req_ready drops. csr_ready is always high.
module valve_motor_position_sequencer_core #(
   parameter int POSITION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  vmps_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output vmps_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vmps_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [vmps_pkg::CsrDataBits-1:0]    csr_wdata
);

   logic              s1_valid_ff, s1_valid_in;
   vmps_pkg::req_type s1_req_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   vmps_pkg::rsp_type rsp_data_ff;
   logic              advance;
   vmps_pkg::cfg_type cfg;
   vmps_pkg::rsp_type step_rsp;

   vmps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vmps_step_logic #(
      .POSITION_BITS (POSITION_BITS)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (s1_req_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   assign csr_ready = 1'b1;
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_stop_not_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.stopped && rsp_data_ff.running))
      else $error("stopped result still running");

   a_step_while_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.step_action != vmps_pkg::ACT_NONE
      |-> rsp_data_ff.running && !rsp_data_ff.stopped)
      else $error("step without motion");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.step_action == vmps_pkg::ACT_NONE ||
                        rsp_data_ff.step_action == vmps_pkg::ACT_OPEN ||
                        rsp_data_ff.step_action == vmps_pkg::ACT_CLOSE))
      else $error("bad step action");

   a_held_request: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("pending request lost");

endmodule

// ===== sim/vmps_tb_pkg.sv =====
package vmps_tb_pkg;
   import vmps_pkg::*;

   // codes the block does not define; driven to check that they are ignored
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam logic [CsrIndexBits-1:0] CSR_SPARE = 3'd5;

   localparam int unsigned MaxPrinted = 40;

   class step_tracker;
      logic [7:0]  step_interval;
      logic [9:0]  max_overrun;
      logic [7:0]  zero_extra;
      logic [15:0] power_on_pos;
      logic        motor_enable;

      logic [15:0] cur_pos;
      logic [15:0] goal_pos;
      logic        moving;
      logic [7:0]  tick_count;
      logic [9:0]  overrun;
      logic [7:0]  pending_os;

      rsp_type     pending_results[$];
      int unsigned mismatches;
      int unsigned results_checked;

      function new();
         step_interval   = RST_STEP_INTERVAL;
         max_overrun     = RST_OVERRUN_LIMIT;
         zero_extra      = RST_ZERO_EXTRA_PULSES;
         power_on_pos    = RST_POWER_ON_POSITION;
         motor_enable    = RST_MOTOR_ENABLE;
         cur_pos         = '0;
         goal_pos        = '0;
         moving          = 1'b0;
         tick_count      = '0;
         overrun         = '0;
         pending_os      = '0;
         mismatches      = 0;
         results_checked = 0;
      endfunction

      static function logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
         logic [16:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[16] ? 16'hFFFF : s[15:0];
      endfunction

      function void write_register(logic [CsrIndexBits-1:0] index,
                                   logic [CsrDataBits-1:0] wdata);
         case (index)
            CSR_STEP_INTERVAL:     step_interval = wdata[7:0];
            CSR_OVERRUN_LIMIT:     max_overrun   = wdata[9:0];
            CSR_ZERO_EXTRA_PULSES: zero_extra    = wdata[7:0];
            CSR_POWER_ON_POSITION: power_on_pos  = wdata[15:0];
            CSR_MOTOR_ENABLE:      motor_enable  = wdata[0];
            default: ;
         endcase
      endfunction

      function void take_request(req_type req);
         rsp_type     want;
         logic [1:0]  action;
         logic        done;
         logic [15:0] os_wide;
         action  = ACT_NONE;
         done    = 1'b0;
         os_wide = {8'd0, pending_os};
         case (req.cmd)
            CMD_TICK: begin
               if (tick_count != 0) begin
                  tick_count = tick_count - 8'd1;
               end else begin
                  tick_count = step_interval;
                  if (motor_enable && moving) begin
                     if (goal_pos == cur_pos) begin
                        // take back the open overshoot before stopping
                        if (pending_os != 0) begin
                           goal_pos   = (os_wide > goal_pos) ? '0 : goal_pos - os_wide;
                           pending_os = '0;
                        end else begin
                           moving = 1'b0;
                           done   = 1'b1;
                        end
                     end else if (goal_pos > cur_pos) begin
                        cur_pos = sat_add(cur_pos, 16'd1);
                        action  = ACT_OPEN;
                     end else if (req.origin_sensed && overrun >= max_overrun) begin
                        // home to zero once the overrun limit is reached
                        cur_pos  = '0;
                        goal_pos = '0;
                        moving   = 1'b0;
                        done     = 1'b1;
                     end else begin
                        if (req.origin_sensed) overrun = overrun + 10'd1;
                        cur_pos = cur_pos - 16'd1;
                        action  = ACT_CLOSE;
                     end
                  end
               end
            end
            CMD_MOVE: begin
               if (!moving && cur_pos != req.target_pos) begin
                  moving     = 1'b1;
                  tick_count = step_interval;
                  overrun    = '0;
                  pending_os = '0;
                  if (req.target_pos == 0) begin
                     cur_pos = sat_add(cur_pos, {8'd0, zero_extra});
                  end else if (cur_pos < req.target_pos) begin
                     pending_os = req.open_overshoot;
                  end
                  goal_pos = sat_add(req.target_pos, {8'd0, pending_os});
               end
            end
            CMD_INIT: begin
               cur_pos = req.origin_sensed ? '0 : power_on_pos;
            end
            default: ;
         endcase
         want.step_action = action;
         want.running     = moving;
         want.position    = cur_pos;
         want.stopped     = done;
         pending_results.push_back(want);
      endfunction

      task report(string msg);
         if (mismatches < MaxPrinted) $display("MISMATCH %s", msg);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result %h arrived with none expected", got));
            return;
         end
         want = pending_results.pop_front();
         results_checked++;
         if (got.step_action !== want.step_action)
            report($sformatf("result %0d step_action %0d, expected %0d",
                             results_checked, got.step_action, want.step_action));
         if (got.running !== want.running)
            report($sformatf("result %0d running %0d, expected %0d",
                             results_checked, got.running, want.running));
         if (got.position !== want.position)
            report($sformatf("result %0d position %0d, expected %0d",
                             results_checked, got.position, want.position));
         if (got.stopped !== want.stopped)
            report($sformatf("result %0d stopped %0d, expected %0d",
                             results_checked, got.stopped, want.stopped));
      endtask
   endclass

endpackage

// ===== sim/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vmps_pkg::*;
   import vmps_tb_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 6;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   req_type                 req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   rsp_type                 rsp_data;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0]  csr_wdata;

   step_tracker tracker = new();

   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned requests_sent     = 0;
   int unsigned settings_applied  = 0;
   int          idle_cycles       = 0;

   valve_motor_position_sequencer_core #(
      .POSITION_BITS(16)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: sample at the edge, then choose next cycle's ready
   initial begin : result_sink
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) tracker.check_result(rsp_data);
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_request(logic [1:0] cmd, logic [15:0] target,
                                            logic [7:0] overshoot, logic origin);
      req_type r;
      r.cmd            = cmd;
      r.target_pos     = target;
      r.open_overshoot = overshoot;
      r.origin_sensed  = origin;
      return r;
   endfunction

   // keep runs short: far targets only where a sensed origin ends them early
   function automatic logic [15:0] pick_move_target();
      logic [15:0] cur;
      logic [15:0] tgt;
      logic [15:0] delta;
      logic [16:0] span;
      logic        closing;
      int unsigned pick;
      cur   = tracker.cur_pos;
      delta = 16'($urandom_range(1, 16));
      pick  = $urandom_range(99);
      if (pick < 35)      tgt = step_tracker::sat_add(cur, delta);
      else if (pick < 65) tgt = (cur > delta) ? cur - delta : '0;
      else if (pick < 75) tgt = '0;
      else if (pick < 80) tgt = cur;
      else                tgt = 16'($urandom);
      closing = (tgt == 0) || (tgt < cur);
      if (tgt == 0)    span = {1'b0, cur} + {9'd0, tracker.zero_extra};
      else if (closing) span = {1'b0, cur - tgt};
      else             span = {1'b0, tgt - cur};
      if (span > 300 && !(closing && tracker.motor_enable && tracker.max_overrun <= 16))
         tgt = cur;
      return tgt;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      r    = make_request(CMD_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
      pick = $urandom_range(99);
      if (pick < 4) begin
         r.cmd = CMD_SPARE;
      end else if (pick < 8 && !tracker.moving) begin
         r.cmd = CMD_INIT;
      end else if (pick < 24) begin
         r.cmd = CMD_MOVE;
         if (!tracker.moving) begin
            r.target_pos     = pick_move_target();
            r.open_overshoot = ($urandom_range(29) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(6));
         end
      end else if (tracker.moving && tracker.cur_pos > tracker.goal_pos &&
                   tracker.cur_pos - tracker.goal_pos > 64) begin
         r.origin_sensed = 1'b1;
      end
      return r;
   endfunction

   task automatic send_request(input req_type r);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      tracker.take_request(r);
      requests_sent++;
   endtask

   task automatic wait_idle();
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexBits-1:0] index,
                                 input logic [CsrDataBits-1:0] wdata);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(index, wdata);
   endtask

   // unused upper data bits carry noise
   task automatic apply_setting(input logic [7:0] interval, input logic [9:0] limit,
                                input logic [7:0] extra, input logic [15:0] power_pos,
                                input logic enable);
      req_valid <= 1'b0;
      wait_idle();
      write_register(CSR_STEP_INTERVAL, {8'($urandom), interval});
      write_register(CSR_OVERRUN_LIMIT, {6'($urandom), limit});
      write_register(CSR_ZERO_EXTRA_PULSES, {8'($urandom), extra});
      write_register(CSR_POWER_ON_POSITION, power_pos);
      write_register(CSR_MOTOR_ENABLE, {15'($urandom), enable});
      write_register(CSR_SPARE, 16'($urandom));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic run_random(input int unsigned count, input int unsigned send_idle,
                             input int unsigned recv_idle);
      sender_idle_pct   = send_idle;
      receiver_idle_pct = recv_idle;
      repeat (count) send_request(random_request());
   endtask

   initial begin : stimulus
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      sender_idle_pct   = 30;
      receiver_idle_pct = 70;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      send_request(make_request(CMD_SPARE, 16'hFFFF, 8'hFF, 1'b1));
      send_request(make_request(CMD_TICK, 16'h0000, 8'h00, 1'b0));
      send_request(make_request(CMD_INIT, 16'h1234, 8'h00, 1'b0));
      send_request(make_request(CMD_INIT, 16'h0000, 8'h00, 1'b1));
      send_request(make_request(CMD_MOVE, 16'h0000, 8'hFF, 1'b0));
      send_request(make_request(CMD_INIT, 16'h0000, 8'h00, 1'b0));

      // prescaler off, home at once, largest extra pulses and power-on position
      apply_setting(8'd0, 10'd0, 8'd255, 16'hFFFF, 1'b1);
      send_request(make_request(CMD_MOVE, 16'h0000, 8'h0F, 1'b0));
      send_request(make_request(CMD_MOVE, 16'h00AA, 8'h00, 1'b0));
      send_request(make_request(CMD_TICK, 16'h0000, 8'h00, 1'b1));
      send_request(make_request(CMD_INIT, 16'h0000, 8'h00, 1'b0));
      send_request(make_request(CMD_MOVE, 16'hFFFF, 8'h10, 1'b0));
      send_request(make_request(CMD_MOVE, 16'hFFFE, 8'h09, 1'b0));
      send_request(make_request(CMD_TICK, 16'h0000, 8'h00, 1'b0));
      send_request(make_request(CMD_TICK, 16'h0000, 8'h00, 1'b0));
      send_request(make_request(CMD_MOVE, 16'hFFFF, 8'd200, 1'b0));
      send_request(make_request(CMD_TICK, 16'h0000, 8'h00, 1'b0));
      send_request(make_request(CMD_TICK, 16'h0000, 8'h00, 1'b0));
      send_request(make_request(CMD_TICK, 16'h0000, 8'h00, 1'b1));
      send_request(make_request(CMD_MOVE, 16'h0003, 8'h02, 1'b0));
      send_request(make_request(CMD_INIT, 16'h0000, 8'h00, 1'b0));
      send_request(make_request(CMD_TICK, 16'h0000, 8'h00, 1'b1));
      send_request(make_request(CMD_TICK, 16'h0000, 8'h00, 1'b0));

      apply_setting(8'd0, 10'd3, 8'd5, 16'd1000, 1'b1);
      run_random(260, 30, 70);
      apply_setting(8'd255, 10'd1023, 8'd255, 16'hFFFF, 1'b1);
      run_random(120, 30, 70);
      apply_setting(8'd1, 10'd0, 8'd0, 16'h0000, 1'b1);
      run_random(300, 70, 30);
      apply_setting(8'd2, 10'($urandom_range(16)), 8'($urandom), 16'($urandom), 1'b0);
      run_random(100, 70, 30);
      apply_setting(8'($urandom_range(3)), 10'($urandom_range(16)), 8'($urandom),
                    16'($urandom), 1'b1);
      run_random(330, 0, 0);
      apply_setting(8'd0, 10'd10, 8'd30, 16'd65500, 1'b1);
      run_random(320, 0, 0);

      req_valid <= 1'b0;
      wait_idle();
      if (tracker.pending_results.size() != 0)
         tracker.report($sformatf("%0d results never arrived", tracker.pending_results.size()));

      $display("run: %0d requests and %0d results compared under %0d register settings",
               requests_sent, tracker.results_checked, settings_applied);
      $display("run: ticks, moves, inits and spare codes with three idle patterns, %0d mismatches",
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
